// File: src/mfek_pkg.sv
// Package for the Edmonds-Karp max flow block: sizes, types and the sequencer states.
// No dependencies; imported by max_flow_edmonds_karp_top (mfek_ram does not use it).
package mfek_pkg;

   localparam int MaxVertices = 16;
   localparam int CapBits     = 16;
   localparam int VtxBits     = $clog2(MaxVertices);
   localparam int AddrBits    = 2 * VtxBits;
   localparam int ResBits     = CapBits + 1;
   localparam int FlowBits    = 20;
   localparam int CntBits     = VtxBits + 1;

   typedef logic [VtxBits-1:0]  vtx_type;
   typedef logic [AddrBits-1:0] addr_type;
   typedef logic [ResBits-1:0]  res_type;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RUN  = 1'b1;

   // Sequencer states, one-hot.
   typedef enum logic [9:0] {
      ST_IDLE   = 10'b0000000001,
      ST_COPY   = 10'b0000000010,
      ST_INIT   = 10'b0000000100,
      ST_POP    = 10'b0000001000,
      ST_SCAN   = 10'b0000010000,
      ST_CHECK  = 10'b0000100000,
      ST_AUGA   = 10'b0001000000,
      ST_AUGB   = 10'b0010000000,
      ST_AUGC   = 10'b0100000000,
      ST_DONE   = 10'b1000000000
   } state_type;

   // Single request to the residual memory.
   typedef struct packed {
      logic     wr;
      addr_type addr;
      res_type  wdata;
   } res_req_type;

endpackage

// File: src/mfek_ram.sv
// Generic single-port RAM with registered read data; used for capacity and residual stores.
// Depends on nothing but its parameters.
module mfek_ram #(
   parameter int AW = 8,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          wr,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];

   // One write and one read of the same address per cycle; the read returns the old data.
   always_ff @(posedge clock) begin
      if (wr) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

// File: src/max_flow_edmonds_karp_top.sv
// Max flow by Edmonds-Karp over a 16 x 16 capacity matrix held in RAM.
// A load item is a single write to the capacity RAM; a new item is taken the next cycle.
// A run item copies the matrix into the residual RAM, then runs searches that read the residual
// RAM entry by entry (SCAN, CHECK) and walks each path back edge by edge (AUGA, AUGB, AUGC);
// the single residual RAM port sets the pace.
// After reset a clearing pass zeroes the capacity RAM; no item is taken meanwhile.
module max_flow_edmonds_karp_top
   import mfek_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_opcode,
   input  logic [3:0]          req_from_vertex,
   input  logic [3:0]          req_to_vertex,
   input  logic [15:0]         req_capacity,
   input  logic [3:0]          req_source,
   input  logic [3:0]          req_sink,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [4:0]          csr_vertex_count,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [19:0]         rsp_max_flow
);

   state_type state_ff, state_in;
   logic [4:0] vcount_ff;
   logic [AddrBits:0] clr_ff, clr_in;
   logic [AddrBits:0] cnt_ff, cnt_in;         // copy / scan counter
   vtx_type src_ff, dst_ff, src_in, dst_in;
   vtx_type u_ff, u_in, v_ff, v_in;
   res_type w_ff, w_in;
   res_type bott_ff, bott_in;
   logic [FlowBits-1:0] total_ff, total_in;
   logic [MaxVertices-1:0] vis_ff, vis_in;
   vtx_type par_ff [MaxVertices];
   vtx_type qv_ff [MaxVertices];
   res_type qw_ff [MaxVertices];
   logic [CntBits-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [CntBits-1:0] nlive;
   logic rsp_valid_ff;
   logic [FlowBits-1:0] rsp_data_ff;

   logic cap_wr;
   addr_type cap_addr;
   logic [CapBits-1:0] cap_wdata, cap_rdata;
   res_req_type rq;
   res_type res_rdata;
   logic accept, is_live_run, par_wr, q_wr;
   vtx_type par_idx, par_val;
   res_type nw, rmin;

   mfek_ram #(.AW(AddrBits), .DW(CapBits)) u_cap (
      .clock(clock), .wr(cap_wr), .addr(cap_addr), .wdata(cap_wdata), .rdata(cap_rdata));
   mfek_ram #(.AW(AddrBits), .DW(ResBits)) u_res (
      .clock(clock), .wr(rq.wr), .addr(rq.addr), .wdata(rq.wdata), .rdata(res_rdata));

   // Live vertex count, saturated.
   always_comb begin
      if (vcount_ff == 5'd0) nlive = CntBits'(1);
      else if (vcount_ff > 5'(MaxVertices)) nlive = CntBits'(MaxVertices);
      else nlive = CntBits'(vcount_ff);
   end

   assign req_stall = !(state_ff == ST_IDLE) || !clr_ff[AddrBits] || rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_max_flow = rsp_data_ff;
   assign is_live_run = ({1'b0, req_source} < nlive) && ({1'b0, req_sink} < nlive)
                        && (req_source != req_sink);
   assign rmin = (res_rdata < w_ff) ? res_rdata : w_ff;

   // Capacity RAM port: clear, load, or copy read.
   always_comb begin
      cap_wr = 1'b0;
      cap_addr = cnt_ff[AddrBits-1:0];
      cap_wdata = req_capacity;
      if (!clr_ff[AddrBits]) begin
         cap_wr = 1'b1;
         cap_addr = clr_ff[AddrBits-1:0];
         cap_wdata = '0;
      end else if (accept && req_opcode == OP_LOAD) begin
         cap_wr = 1'b1;
         cap_addr = {req_from_vertex, req_to_vertex};
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      cnt_in = cnt_ff;
      src_in = src_ff;
      dst_in = dst_ff;
      u_in = u_ff;
      v_in = v_ff;
      w_in = w_ff;
      bott_in = bott_ff;
      total_in = total_ff;
      vis_in = vis_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      rq = '{wr: 1'b0, addr: '0, wdata: '0};
      par_wr = 1'b0;
      par_idx = v_ff;
      par_val = u_ff;
      q_wr = 1'b0;
      nw = rmin;
      if (!clr_ff[AddrBits]) clr_in = clr_ff + 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_opcode == OP_RUN) begin
               src_in = req_source;
               dst_in = req_sink;
               total_in = '0;
               cnt_in = '0;
               state_in = ST_COPY;
            end
         end
         ST_COPY: begin
            // Capacity read data is registered; write the previous address.
            if (cnt_ff != '0) begin
               rq.wr = 1'b1;
               rq.addr = AddrBits'(cnt_ff - 1'b1);
               rq.wdata = {1'b0, cap_rdata};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (AddrBits+1)'(2**AddrBits)) begin
               if ({1'b0, src_ff} < nlive && {1'b0, dst_ff} < nlive && src_ff != dst_ff)
                  state_in = ST_INIT;
               else
                  state_in = ST_DONE;
            end
         end
         ST_INIT: begin
            vis_in = '0;
            vis_in[src_ff] = 1'b1;
            head_in = '0;
            tail_in = CntBits'(1);
            q_wr = 1'b1;
            state_in = ST_POP;
         end
         ST_POP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_DONE;
            end else begin
               u_in = qv_ff[head_ff[VtxBits-1:0]];
               w_in = qw_ff[head_ff[VtxBits-1:0]];
               head_in = head_ff + 1'b1;
               v_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rq.addr = {u_ff, v_ff};
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!vis_ff[v_ff] && res_rdata != '0) begin
               vis_in[v_ff] = 1'b1;
               par_wr = 1'b1;
               if (v_ff == dst_ff) begin
                  bott_in = nw;
                  total_in = total_ff + FlowBits'(nw);
                  state_in = ST_AUGA;
               end else if (tail_ff < CntBits'(MaxVertices)) begin
                  q_wr = 1'b1;
                  tail_in = tail_ff + 1'b1;
               end
            end
            if (state_in == ST_CHECK) begin
               if ({1'b0, v_ff} + 1'b1 >= nlive) begin
                  state_in = ST_POP;
               end else begin
                  v_in = v_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_AUGA: begin
            // v_ff is the path vertex; read forward edge parent->v.
            if (v_ff == src_ff) begin
               state_in = ST_INIT;
            end else begin
               u_in = par_ff[v_ff];
               rq.addr = {par_ff[v_ff], v_ff};
               state_in = ST_AUGB;
            end
         end
         ST_AUGB: begin
            rq.wr = 1'b1;
            rq.addr = {u_ff, v_ff};
            rq.wdata = res_rdata - bott_ff;
            cnt_in = '0;
            state_in = ST_AUGC;
         end
         ST_AUGC: begin
            // Read reverse edge v->u, then write it the next cycle; both steps stay in this state.
            rq.addr = {v_ff, u_ff};
            w_in = '0;
            cnt_in = '0;
            state_in = ST_AUGB;
            if (cnt_ff[0]) begin
               rq.wr = 1'b1;
               rq.wdata = res_rdata + bott_ff;
               v_in = u_ff;
               state_in = ST_AUGA;
            end else begin
               cnt_in = (AddrBits+1)'(1);
               state_in = ST_AUGC;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         clr_ff <= '0;
         vcount_ff <= 5'd16;
         rsp_valid_ff <= 1'b0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         total_ff <= total_in;
         if (csr_valid && csr_ready) vcount_ff <= csr_vertex_count;
         if (state_ff == ST_DONE) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      src_ff <= src_in;
      dst_ff <= dst_in;
      u_ff <= u_in;
      v_ff <= v_in;
      w_ff <= w_in;
      bott_ff <= bott_in;
      vis_ff <= vis_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (state_ff == ST_DONE) rsp_data_ff <= total_ff;
      if (par_wr) par_ff[par_idx] <= par_val;
      if (q_wr && state_ff == ST_INIT) begin
         qv_ff[0] <= src_ff;
         qw_ff[0] <= '1;
      end else if (q_wr) begin
         qv_ff[tail_ff[VtxBits-1:0]] <= v_ff;
         qw_ff[tail_ff[VtxBits-1:0]] <= nw;
      end
   end

   // The block never takes an item while a result waits.
   assert property (@(posedge clock) disable iff (reset) rsp_valid_ff |-> req_stall)
      else $error("item accepted while result pending");
   // A run result follows the done state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |=> rsp_valid_ff)
      else $error("done without result");
   // Queue head never passes tail.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> head_ff <= tail_ff)
      else $error("queue underflow");

endmodule
